@@ rtl/core/sorted_table_key_search_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the table key search block
// Clocked on clk_i, quiet while rst_ni is low, report through $error.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_KEY_SEARCH_ASSERT_SVH
`define SORTED_TABLE_KEY_SEARCH_ASSERT_SVH

// Same-cycle implication.
`define STS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("table key search: assertion failed");

// Next-cycle implication.
`define STS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("table key search: assertion failed");

`endif

@@ rtl/core/sts_pkg.sv @@
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types and field widths of the table key search block.
// ----------------------------------------------------------------------------
`default_nettype none

package sts_pkg;

  localparam int unsigned ACT_W  = 2;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned POS_W  = 6;

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_SCAN  = 2'd1,
    ACT_BIN   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_PROBE = 2'd2,
    ST_CMP   = 2'd3
  } state_e;

endpackage

`default_nettype wire

@@ rtl/core/sorted_table_key_search.sv @@
// ----------------------------------------------------------------------------
// sorted_table_key_search
// Table of signed 32-bit entries with linear and binary key search.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: present action_i, entry_index_i and data_value_i with
//   start high; the command transfers at the rising edge where start is high
//   and busy is low.
//   A write command stores data_value_i in the table at entry_index_i in the
//   cycle of its transfer and gives no result; the next command may follow
//   in the very next cycle. Indexes at or above TABLE_DEPTH are dropped, and
//   the undefined action code is dropped too.
//   A search command raises busy and yields one result, shown on found_o,
//   position_o, low_bound_o and high_bound_o for exactly one cycle with
//   done_o high. busy falls in that same cycle, so a new command can
//   transfer while the result is still shown. The receiver cannot stall.
//   Linear search reads one entry per cycle through the single read port of
//   the table memory and stops at the first hit, or reports a miss after all
//   n entries (n = entry_count, capped at TABLE_DEPTH). Binary search splits
//   each probe into a memory read in ST_PROBE, then a compare and bound
//   update in ST_CMP.
//   Config channel: cfg_data_i writes entry_count on a cfg_valid_i /
//   cfg_ready_o transfer, accepted only while no search runs.
//   Reset clears entry_count and the sequencer; table contents stay
//   undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_key_search
  import sts_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // command channel
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [ACT_W-1:0]         action_i,
  input  wire logic [IDX_W-1:0]         entry_index_i,
  input  wire logic signed [DATA_W-1:0] data_value_i,
  // result channel
  output logic                          done_o,
  output logic                          found_o,
  output logic [POS_W-1:0]              position_o,
  output logic [POS_W-1:0]              low_bound_o,
  output logic [POS_W-1:0]              high_bound_o,
  // config channel
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [CNT_W-1:0]         cfg_data_i
);

  // Address width and width of a count 0..TABLE_DEPTH.
  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned NW = $clog2(TABLE_DEPTH + 1);

  // Table memory: one write port, one registered read port.
  logic [DATA_W-1:0] mem_q [TABLE_DEPTH];
  logic [DATA_W-1:0] rd_data_q;
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic              wr_en;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  entry_count_q;
  logic [NW-1:0]     active_n;

  logic [DATA_W-1:0] key_q, key_d;
  logic [NW-1:0]     idx_q, idx_d;       // next entry to read in a linear scan
  logic              pend_q, pend_d;     // a scan read is in flight
  logic [IW-1:0]     pidx_q, pidx_d;     // index of the read in flight / probe
  logic [NW:0]       lo_q, lo_d;         // binary bounds, two's complement
  logic [NW:0]       hi_q, hi_d;
  logic [NW+1:0]     mid_sum;
  logic [NW:0]       mid_ext;

  logic              done_q, done_d;
  logic              found_q, found_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [POS_W-1:0]  lob_q, lob_d;
  logic [POS_W-1:0]  hib_q, hib_d;

  // Cap the count at the table depth.
  assign active_n = (32'(entry_count_q) > 32'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH)
                                                            : NW'(entry_count_q);

  // Floor midpoint; only used while both bounds are non-negative.
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_ext = (NW+1)'(pidx_q);

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);

  assign done_o       = done_q;
  assign found_o      = found_q;
  assign position_o   = pos_q;
  assign low_bound_o  = lob_q;
  assign high_bound_o = hib_q;

  always_comb begin
    state_d = state_q;
    key_d   = key_q;
    idx_d   = idx_q;
    pend_d  = 1'b0;
    pidx_d  = pidx_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    done_d  = 1'b0;
    found_d = found_q;
    pos_d   = pos_q;
    lob_d   = lob_q;
    hib_d   = hib_q;
    rd_en   = 1'b0;
    rd_addr = idx_q[IW-1:0];
    wr_en   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (action_e'(action_i))
            ACT_WRITE: begin
              wr_en = (32'(entry_index_i) < 32'(TABLE_DEPTH));
            end
            ACT_SCAN: begin
              key_d   = data_value_i;
              idx_d   = '0;
              state_d = ST_SCAN;
            end
            ACT_BIN: begin
              key_d   = data_value_i;
              lo_d    = '0;
              hi_d    = {1'b0, active_n} - (NW+1)'(1);
              state_d = ST_PROBE;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Compare the entry read last cycle while the next read is issued.
        if (pend_q && (rd_data_q == key_q)) begin
          done_d  = 1'b1;
          found_d = 1'b1;
          pos_d   = POS_W'(pidx_q);
          lob_d   = POS_W'(pidx_q);
          hib_d   = POS_W'(pidx_q);
          state_d = ST_IDLE;
        end else if (idx_q < active_n) begin
          rd_en   = 1'b1;
          rd_addr = idx_q[IW-1:0];
          pend_d  = 1'b1;
          pidx_d  = idx_q[IW-1:0];
          idx_d   = idx_q + NW'(1);
        end else begin
          done_d  = 1'b1;
          found_d = 1'b0;
          pos_d   = '0;
          lob_d   = '0;
          hib_d   = '0;
          state_d = ST_IDLE;
        end
      end

      ST_PROBE: begin
        if ($signed(lo_q) > $signed(hi_q)) begin
          done_d  = 1'b1;
          found_d = 1'b0;
          pos_d   = '0;
          lob_d   = '0;
          hib_d   = '0;
          state_d = ST_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = mid_sum[IW:1];
          pidx_d  = mid_sum[IW:1];
          state_d = ST_CMP;
        end
      end

      ST_CMP: begin
        if (rd_data_q == key_q) begin
          done_d  = 1'b1;
          found_d = 1'b1;
          pos_d   = POS_W'(pidx_q);
          lob_d   = POS_W'(lo_q);
          hib_d   = POS_W'(hi_q);
          state_d = ST_IDLE;
        end else if ($signed(key_q) < $signed(rd_data_q)) begin
          hi_d    = mid_ext - (NW+1)'(1);
          state_d = ST_PROBE;
        end else begin
          lo_d    = mid_ext + (NW+1)'(1);
          state_d = ST_PROBE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      entry_count_q <= '0;
      pend_q        <= 1'b0;
      done_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        entry_count_q <= cfg_data_i;
      end
    end
  end

  // Datapath and result registers.
  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    idx_q   <= idx_d;
    pidx_q  <= pidx_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    found_q <= found_d;
    pos_q   <= pos_d;
    lob_q   <= lob_d;
    hib_q   <= hib_d;
  end

  // Table memory ports.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[IW'(entry_index_i)] <= data_value_i;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sts_checker.sv @@
// ----------------------------------------------------------------------------
// sts_checker
// Port-level checks of the table key search block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_table_key_search_assert.svh"

module sts_checker
  import sts_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             start_i,
  input wire logic             busy_i,
  input wire logic [ACT_W-1:0] action_i,
  input wire logic             done_i,
  input wire logic             found_i,
  input wire logic [POS_W-1:0] position_i,
  input wire logic [POS_W-1:0] low_bound_i,
  input wire logic [POS_W-1:0] high_bound_i
);

  // A result shows only once the sequencer is back to idle.
  `STS_ASSERT_NOW(a_done_idle, done_i, !busy_i)

  // A miss carries zero position and bounds.
  `STS_ASSERT_NOW(a_miss_zero, done_i && !found_i,
                  position_i == '0 && low_bound_i == '0 && high_bound_i == '0)

  // A result strobe lasts one cycle.
  `STS_ASSERT_NEXT(a_done_pulse, done_i, !done_i)

  // A write transfer never yields a result.
  `STS_ASSERT_NEXT(a_write_silent,
                   start_i && !busy_i && action_i == ACT_WRITE, !done_i && !busy_i)

endmodule

bind sorted_table_key_search sts_checker u_sts_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start),
  .busy_i       (busy),
  .action_i     (action_i),
  .done_i       (done_o),
  .found_i      (found_o),
  .position_i   (position_o),
  .low_bound_i  (low_bound_o),
  .high_bound_i (high_bound_o)
);

`default_nettype wire
